### rtl/tag_value_order_message_parser_assert.svh
// Assertion macros used by the record stage module.
// Each macro checks one property on the rising clock edge; TVO_ASSERT stays quiet
// while the asynchronous active-low reset is asserted, TVO_ASSERT_ALWAYS does not.
`ifndef TAG_VALUE_ORDER_MESSAGE_PARSER_ASSERT_SVH
`define TAG_VALUE_ORDER_MESSAGE_PARSER_ASSERT_SVH

`ifndef SYNTH

// Property checked only while out of reset.
`define TVO_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, during reset as well.
`define TVO_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TVO_ASSERT(name, clk, rstn, prop, msg)
`define TVO_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

### rtl/tvo_pkg.sv
`timescale 1ns / 1ps

package tvo_pkg;

  // Reset value of the field separator: the vertical bar.
  localparam logic [7:0] SEP_RESET = 8'h7C;

  // Characters the parser reacts to.
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;

  // Keys as stored in the key register, first character in the low byte.
  localparam logic [15:0] KEY_1  = 16'h0031;
  localparam logic [15:0] KEY_11 = 16'h3131;
  localparam logic [15:0] KEY_55 = 16'h3535;
  localparam logic [15:0] KEY_54 = 16'h3435;
  localparam logic [15:0] KEY_38 = 16'h3833;
  localparam logic [15:0] KEY_40 = 16'h3034;
  localparam logic [15:0] KEY_44 = 16'h3434;

  // Number scanner phases.
  localparam logic [1:0] PH_SPACE  = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  // Record slots; the six numeric slots index the value array directly.
  localparam logic [2:0] SLOT_ORDER  = 3'd0;
  localparam logic [2:0] SLOT_CLIENT = 3'd1;
  localparam logic [2:0] SLOT_SIDE   = 3'd2;
  localparam logic [2:0] SLOT_QTY    = 3'd3;
  localparam logic [2:0] SLOT_KIND   = 3'd4;
  localparam logic [2:0] SLOT_PRICE  = 3'd5;
  localparam logic [2:0] SLOT_INSTR  = 3'd6;
  localparam logic [2:0] SLOT_NONE   = 3'd7;

  // Status codes of a record.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_NUM  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // Parse state of the field being collected.
  typedef struct packed {
    logic [1:0]  piece_count;
    logic        last_eq;
    logic [15:0] key_chars;
    logic [1:0]  key_len;
    logic [3:0]  val_len;
    logic [1:0]  phase;
    logic [31:0] mag;
    logic        neg;
    logic        num_err;
    logic [63:0] text;
  } field_t;

  // All zero is the cleared field; the phase then reads as PH_SPACE.
  localparam field_t FIELD_CLEAR = '0;

  // A closed field handed to the record stage.
  typedef struct packed {
    field_t field;
    logic   emit;
  } close_t;

  // Record being assembled, also the payload of a result item.
  typedef struct packed {
    logic [5:0][31:0] vals;
    logic [63:0]      instrument;
    logic [3:0]       instr_len;
    logic [6:0]       mask;
    logic [1:0]       status;
  } record_t;

endpackage

### rtl/tvo_if.sv
`timescale 1ns / 1ps

// Message byte channel.
interface tvo_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

// Separator register write channel.
interface tvo_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] field_separator;

  modport source (output valid, output field_separator, input ready);
  modport sink (input valid, input field_separator, output ready);
endinterface

// Parsed record channel.
interface tvo_out_if;
  logic               valid;
  logic               ready;
  logic [6:0]         present_mask;
  logic signed [31:0] order_id;
  logic signed [31:0] client_id;
  logic signed [31:0] side_code;
  logic signed [31:0] order_quantity;
  logic signed [31:0] order_kind;
  logic signed [31:0] limit_price;
  logic [63:0]        instrument_text;
  logic [3:0]         instrument_length;
  logic [1:0]         status;

  modport source (
    output valid, output present_mask, output order_id, output client_id,
    output side_code, output order_quantity, output order_kind,
    output limit_price, output instrument_text, output instrument_length,
    output status, input ready
  );
  modport sink (
    input valid, input present_mask, input order_id, input client_id,
    input side_code, input order_quantity, input order_kind,
    input limit_price, input instrument_text, input instrument_length,
    input status, output ready
  );
endinterface

### rtl/tvo_field.sv
`timescale 1ns / 1ps

module tvo_field #(
  parameter int unsigned INSTRUMENT_BYTES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tvo_cfg_if.sink         cfg_i,
  tvo_in_if.sink          in_i,
  input  logic            advance_i,
  output logic            close_valid_o,
  output tvo_pkg::close_t close_o
);

  logic [7:0]      sep_q;
  logic            in_v_q;
  logic [7:0]      byte_q;
  logic            last_q;
  tvo_pkg::field_t fld_q;
  tvo_pkg::field_t fld_d;
  logic            is_sep;
  logic            is_eq;
  logic            is_digit;
  logic            is_space;
  logic [34:0]     mag_next;
  logic            snap_v_q;
  tvo_pkg::close_t snap_q;

  // Separator register; write it only while the block is idle, which the block does not enforce.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= tvo_pkg::SEP_RESET;
    end else if (cfg_i.valid) begin
      sep_q <= cfg_i.field_separator;
    end
  end

  // Input register; the whole pipeline moves when the result side has room.
  assign in_i.ready = advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (advance_i) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && in_i.valid) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.is_last;
    end
  end

  // Character classes of the registered byte.
  assign is_sep   = (byte_q == sep_q);
  assign is_eq    = (byte_q == tvo_pkg::CHAR_EQUALS);
  assign is_digit = (byte_q >= tvo_pkg::CHAR_ZERO) && (byte_q <= tvo_pkg::CHAR_NINE);
  assign is_space = (byte_q == tvo_pkg::CHAR_SPACE) ||
                    ((byte_q >= tvo_pkg::CHAR_TAB) && (byte_q <= tvo_pkg::CHAR_CR));

  // Decimal accumulate: ten times the magnitude plus the new digit.
  assign mag_next = {fld_q.mag, 3'b000} + {2'b00, fld_q.mag, 1'b0} + {31'd0, byte_q[3:0]};

  // Field state after this byte.
  always_comb begin
    fld_d = fld_q;
    if (is_sep) begin
      fld_d = tvo_pkg::FIELD_CLEAR;
    end else if (is_eq) begin
      if (fld_q.piece_count != 2'd3) begin
        fld_d.piece_count = fld_q.piece_count + 2'd1;
      end
      fld_d.last_eq = 1'b1;
    end else begin
      fld_d.last_eq = 1'b0;
      if (fld_q.piece_count == 2'd0) begin
        // Key bytes: the first two are kept, the length saturates at three.
        if (fld_q.key_len == 2'd0) begin
          fld_d.key_chars[7:0] = byte_q;
        end else if (fld_q.key_len == 2'd1) begin
          fld_d.key_chars[15:8] = byte_q;
        end
        if (fld_q.key_len != 2'd3) begin
          fld_d.key_len = fld_q.key_len + 2'd1;
        end
      end else if (fld_q.piece_count == 2'd1) begin
        // Value bytes: text capture and the number scanner run side by side.
        for (int i = 0; i < INSTRUMENT_BYTES; i++) begin
          if (fld_q.val_len == 4'(i)) begin
            fld_d.text[i*8 +: 8] = byte_q;
          end
        end
        if (fld_q.val_len != 4'd15) begin
          fld_d.val_len = fld_q.val_len + 4'd1;
        end
        if (fld_q.phase != tvo_pkg::PH_STOP) begin
          if (is_digit) begin
            if (mag_next > 35'd2147483648) begin
              fld_d.num_err = 1'b1;
              fld_d.phase   = tvo_pkg::PH_STOP;
            end else begin
              fld_d.mag   = mag_next[31:0];
              fld_d.phase = tvo_pkg::PH_DIGITS;
            end
          end else if ((fld_q.phase == tvo_pkg::PH_SPACE) && is_space) begin
            fld_d.phase = tvo_pkg::PH_SPACE;
          end else if ((fld_q.phase == tvo_pkg::PH_SPACE) &&
                       ((byte_q == tvo_pkg::CHAR_PLUS) || (byte_q == tvo_pkg::CHAR_MINUS))) begin
            fld_d.neg   = (byte_q == tvo_pkg::CHAR_MINUS);
            fld_d.phase = tvo_pkg::PH_SIGN;
          end else begin
            if (fld_q.phase != tvo_pkg::PH_DIGITS) begin
              fld_d.num_err = 1'b1;
            end
            fld_d.phase = tvo_pkg::PH_STOP;
          end
        end
      end
    end
  end

  // Field state register; the end of a message starts a fresh field.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_q <= tvo_pkg::FIELD_CLEAR;
    end else if (advance_i && in_v_q) begin
      fld_q <= last_q ? tvo_pkg::FIELD_CLEAR : fld_d;
    end
  end

  // Closed field register. A separator closes the field before it; a last
  // byte that is not a separator closes the field it completes. The empty
  // field after a final separator needs no close of its own.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_v_q <= 1'b0;
    end else if (advance_i) begin
      snap_v_q <= in_v_q && (is_sep || last_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && in_v_q) begin
      snap_q.field <= is_sep ? fld_q : fld_d;
      snap_q.emit  <= last_q;
    end
  end

  assign close_valid_o = snap_v_q;
  assign close_o       = snap_q;

endmodule

### rtl/tvo_record.sv
`timescale 1ns / 1ps

`include "tag_value_order_message_parser_assert.svh"

module tvo_record #(
  parameter int unsigned INSTRUMENT_BYTES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            close_valid_i,
  input  tvo_pkg::close_t close_i,
  output logic            advance_o,
  tvo_out_if.source       out_o
);

  tvo_pkg::field_t  fld;
  logic             field_ok;
  logic [2:0]       slot;
  logic [6:0]       slot_bit;
  logic             num_bad;
  logic [31:0]      num_val;
  tvo_pkg::record_t rec_q;
  tvo_pkg::record_t rec_d;
  logic             take;
  logic             emit_new;
  logic             out_v_q;
  tvo_pkg::record_t out_q;
  logic             skid_v_q;
  tvo_pkg::record_t skid_q;

  assign fld = close_i.field;

  // A field counts with a non-empty value and exactly two pieces.
  assign field_ok = (fld.val_len != 4'd0) &&
                    (((fld.piece_count == 2'd1) && !fld.last_eq) ||
                     ((fld.piece_count == 2'd2) && fld.last_eq));

  // Key decoder.
  always_comb begin
    slot     = tvo_pkg::SLOT_NONE;
    slot_bit = 7'd0;
    if (field_ok) begin
      unique case ({fld.key_len, fld.key_chars})
        {2'd1, tvo_pkg::KEY_1}: begin
          slot     = tvo_pkg::SLOT_CLIENT;
          slot_bit = 7'b000_0010;
        end
        {2'd2, tvo_pkg::KEY_11}: begin
          slot     = tvo_pkg::SLOT_ORDER;
          slot_bit = 7'b000_0001;
        end
        {2'd2, tvo_pkg::KEY_55}: begin
          slot     = tvo_pkg::SLOT_INSTR;
          slot_bit = 7'b000_0100;
        end
        {2'd2, tvo_pkg::KEY_54}: begin
          slot     = tvo_pkg::SLOT_SIDE;
          slot_bit = 7'b000_1000;
        end
        {2'd2, tvo_pkg::KEY_38}: begin
          slot     = tvo_pkg::SLOT_QTY;
          slot_bit = 7'b001_0000;
        end
        {2'd2, tvo_pkg::KEY_40}: begin
          slot     = tvo_pkg::SLOT_KIND;
          slot_bit = 7'b010_0000;
        end
        {2'd2, tvo_pkg::KEY_44}: begin
          slot     = tvo_pkg::SLOT_PRICE;
          slot_bit = 7'b100_0000;
        end
        default: begin
          slot     = tvo_pkg::SLOT_NONE;
          slot_bit = 7'd0;
        end
      endcase
    end
  end

  // Number result: no digits, a scan error or a positive 2^31 is bad.
  assign num_bad = fld.num_err || (fld.phase == tvo_pkg::PH_SPACE) ||
                   (fld.phase == tvo_pkg::PH_SIGN) || (!fld.neg && fld.mag[31]);
  assign num_val = fld.neg ? (32'd0 - fld.mag) : fld.mag;

  // Record after this closed field; the first error is kept.
  always_comb begin
    rec_d = rec_q;
    if (slot == tvo_pkg::SLOT_INSTR) begin
      if (fld.val_len > 4'(INSTRUMENT_BYTES)) begin
        if (rec_q.status == tvo_pkg::STATUS_OK) begin
          rec_d.status = tvo_pkg::STATUS_TOO_LONG;
        end
      end else begin
        rec_d.instrument = fld.text;
        rec_d.instr_len  = fld.val_len;
        rec_d.mask       = rec_q.mask | slot_bit;
      end
    end else if (slot != tvo_pkg::SLOT_NONE) begin
      if (num_bad) begin
        if (rec_q.status == tvo_pkg::STATUS_OK) begin
          rec_d.status = tvo_pkg::STATUS_BAD_NUM;
        end
      end else begin
        rec_d.vals[slot] = num_val;
        rec_d.mask       = rec_q.mask | slot_bit;
      end
    end
  end

  assign take     = close_valid_i && advance_o;
  assign emit_new = take && close_i.emit;

  // Record register, cleared once its record is handed to the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (take) begin
      rec_q <= close_i.emit ? '0 : rec_d;
    end
  end

  // Result register with a skid stage; the pipeline halts only while the
  // skid stage holds an item.
  assign advance_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && out_o.ready) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= emit_new;
      end
    end else if (!out_v_q) begin
      out_v_q <= emit_new;
    end else if (emit_new) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && out_o.ready && skid_v_q) begin
      out_q <= skid_q;
    end else if ((!out_v_q || out_o.ready) && emit_new) begin
      out_q <= rec_d;
    end else if (out_v_q && !out_o.ready && emit_new) begin
      skid_q <= rec_d;
    end
  end

  // Output channel.
  assign out_o.valid             = out_v_q;
  assign out_o.present_mask      = out_q.mask;
  assign out_o.order_id          = out_q.vals[tvo_pkg::SLOT_ORDER];
  assign out_o.client_id         = out_q.vals[tvo_pkg::SLOT_CLIENT];
  assign out_o.side_code         = out_q.vals[tvo_pkg::SLOT_SIDE];
  assign out_o.order_quantity    = out_q.vals[tvo_pkg::SLOT_QTY];
  assign out_o.order_kind        = out_q.vals[tvo_pkg::SLOT_KIND];
  assign out_o.limit_price       = out_q.vals[tvo_pkg::SLOT_PRICE];
  assign out_o.instrument_text   = out_q.instrument;
  assign out_o.instrument_length = out_q.instr_len;
  assign out_o.status            = out_q.status;

  // The skid stage only fills behind a waiting result.
  `TVO_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_v_q |-> out_v_q, "skid item without result")

  // After a record goes out the next one starts empty.
  `TVO_ASSERT(a_record_cleared, clk_i, rst_ni, emit_new |=> (rec_q.mask == 7'd0 && rec_q.status == tvo_pkg::STATUS_OK), "record not cleared after emit")

  // A captured instrument never claims more bytes than are stored.
  `TVO_ASSERT(a_instr_len, clk_i, rst_ni, out_v_q |-> (out_q.instr_len <= 4'(INSTRUMENT_BYTES)), "instrument length out of range")

  // No status code beyond the defined ones.
  `TVO_ASSERT(a_status_code, clk_i, rst_ni, out_v_q |-> (out_q.status != 2'd3), "undefined status code")

endmodule

### rtl/tag_value_order_message_parser.sv
// Tag-value order message parser: one message byte per cycle, one record per message.
// Throughput is one byte per cycle while ready is high; neither the byte stage nor the
// record stage iterates.
// The last byte passes the input and closed field registers before the result register.
// Ready drops only while a second record waits in the skid stage behind an untaken one.
// Reset clears parse and record state and sets the separator to the vertical bar.
`timescale 1ns / 1ps

module tag_value_order_message_parser #(
  parameter int unsigned INSTRUMENT_BYTES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tvo_cfg_if.sink   cfg_i,
  tvo_in_if.sink    in_i,
  tvo_out_if.source out_o
);

  logic            advance;
  logic            close_valid;
  tvo_pkg::close_t close_field;

  // Byte stage: separator register, input register, field scanner and closed field register.
  tvo_field #(
    .INSTRUMENT_BYTES(INSTRUMENT_BYTES)
  ) u_field (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .in_i         (in_i),
    .advance_i    (advance),
    .close_valid_o(close_valid),
    .close_o      (close_field)
  );

  // Record stage: key decode, record update and result register.
  tvo_record #(
    .INSTRUMENT_BYTES(INSTRUMENT_BYTES)
  ) u_record (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .close_valid_i(close_valid),
    .close_i      (close_field),
    .advance_o    (advance),
    .out_o        (out_o)
  );

endmodule

### test/tb_tag_value_order_message_parser.sv
`timescale 1ns / 1ps

module tb_tag_value_order_message_parser;

  localparam int INSTR_BYTES = 8;
  localparam int ITEM_GOAL = 850;
  localparam int PHASES = 6;
  localparam int MIN_RECORDS = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_SLACK = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_MISMATCHES = 10;

  // Predicts the record of each message and checks the records that come out.
  class parser_scoreboard;
    logic [7:0] separator;
    tvo_pkg::field_t fld;
    tvo_pkg::record_t rec;
    tvo_pkg::record_t expected_records[$];
    int unsigned failures;
    string value_names[6];

    function new();
      separator = tvo_pkg::SEP_RESET;
      fld = tvo_pkg::FIELD_CLEAR;
      rec = '0;
      failures = 0;
      value_names = '{"order_id", "client_id", "side_code", "order_quantity",
                      "order_kind", "limit_price"};
    endfunction

    // Decimal scanner with leading whitespace, an optional sign and overflow detection.
    function void scan_number(logic [7:0] c);
      bit is_digit;
      bit is_space;
      logic [35:0] next_mag;
      if (fld.phase == tvo_pkg::PH_STOP) return;
      is_digit = c >= tvo_pkg::CHAR_ZERO && c <= tvo_pkg::CHAR_NINE;
      is_space = c == tvo_pkg::CHAR_SPACE ||
                 (c >= tvo_pkg::CHAR_TAB && c <= tvo_pkg::CHAR_CR);
      if (is_digit) begin
        next_mag = {4'd0, fld.mag} * 36'd10 + 36'(c - tvo_pkg::CHAR_ZERO);
        if (next_mag > 36'd2147483648) begin
          fld.num_err = 1'b1;
          fld.phase = tvo_pkg::PH_STOP;
        end else begin
          fld.mag = next_mag[31:0];
          fld.phase = tvo_pkg::PH_DIGITS;
        end
      end else if (fld.phase == tvo_pkg::PH_SPACE && is_space) begin
        // Leading whitespace is skipped.
      end else if (fld.phase == tvo_pkg::PH_SPACE &&
                   (c == tvo_pkg::CHAR_PLUS || c == tvo_pkg::CHAR_MINUS)) begin
        fld.neg = c == tvo_pkg::CHAR_MINUS;
        fld.phase = tvo_pkg::PH_SIGN;
      end else begin
        if (fld.phase != tvo_pkg::PH_DIGITS) fld.num_err = 1'b1;
        fld.phase = tvo_pkg::PH_STOP;
      end
    endfunction

    // Only the first error of a message is kept.
    function void flag_error(logic [1:0] code);
      if (rec.status == tvo_pkg::STATUS_OK) rec.status = code;
    endfunction

    // Decides whether the finished field is taken and updates the record.
    function void close_field();
      bit taken;
      bit bad;
      logic [2:0] slot;
      int mask_pos;
      taken = fld.val_len != 4'd0 &&
              ((fld.piece_count == 2'd1 && !fld.last_eq) ||
               (fld.piece_count == 2'd2 && fld.last_eq));
      slot = tvo_pkg::SLOT_NONE;
      mask_pos = 0;
      if (taken && fld.key_len == 2'd1 && fld.key_chars == tvo_pkg::KEY_1) begin
        slot = tvo_pkg::SLOT_CLIENT;
        mask_pos = 1;
      end else if (taken && fld.key_len == 2'd2) begin
        case (fld.key_chars)
          tvo_pkg::KEY_11: begin slot = tvo_pkg::SLOT_ORDER; mask_pos = 0; end
          tvo_pkg::KEY_55: begin slot = tvo_pkg::SLOT_INSTR; mask_pos = 2; end
          tvo_pkg::KEY_54: begin slot = tvo_pkg::SLOT_SIDE;  mask_pos = 3; end
          tvo_pkg::KEY_38: begin slot = tvo_pkg::SLOT_QTY;   mask_pos = 4; end
          tvo_pkg::KEY_40: begin slot = tvo_pkg::SLOT_KIND;  mask_pos = 5; end
          tvo_pkg::KEY_44: begin slot = tvo_pkg::SLOT_PRICE; mask_pos = 6; end
          default: slot = tvo_pkg::SLOT_NONE;
        endcase
      end
      if (slot == tvo_pkg::SLOT_INSTR) begin
        if (fld.val_len > INSTR_BYTES) begin
          flag_error(tvo_pkg::STATUS_TOO_LONG);
        end else begin
          rec.instrument = fld.text;
          rec.instr_len = fld.val_len;
          rec.mask[mask_pos] = 1'b1;
        end
      end else if (slot != tvo_pkg::SLOT_NONE) begin
        bad = fld.num_err || fld.phase == tvo_pkg::PH_SPACE ||
              fld.phase == tvo_pkg::PH_SIGN ||
              (!fld.neg && fld.mag > 32'h7FFF_FFFF);
        if (bad) begin
          flag_error(tvo_pkg::STATUS_BAD_NUM);
        end else begin
          rec.vals[slot] = fld.neg ? -fld.mag : fld.mag;
          rec.mask[mask_pos] = 1'b1;
        end
      end
      fld = tvo_pkg::FIELD_CLEAR;
    endfunction

    // Called for every accepted input item.
    function void note_byte(logic [7:0] c, bit last);
      if (c == separator) begin
        close_field();
      end else if (c == tvo_pkg::CHAR_EQUALS) begin
        if (fld.piece_count != 2'd3) fld.piece_count = fld.piece_count + 2'd1;
        fld.last_eq = 1'b1;
      end else begin
        fld.last_eq = 1'b0;
        if (fld.piece_count == 2'd0) begin
          if (fld.key_len < 2'd2) fld.key_chars[8*fld.key_len +: 8] = c;
          if (fld.key_len != 2'd3) fld.key_len = fld.key_len + 2'd1;
        end else if (fld.piece_count == 2'd1) begin
          if (fld.val_len < INSTR_BYTES) fld.text[8*fld.val_len +: 8] = c;
          if (fld.val_len != 4'd15) fld.val_len = fld.val_len + 4'd1;
          scan_number(c);
        end
      end
      if (last) begin
        close_field();
        expected_records.insert(expected_records.size(), rec);
        rec = '0;
      end
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= SHOWN_MISMATCHES)
          $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
    endfunction

    // Called for every accepted result item.
    function void check_record(tvo_pkg::record_t got);
      tvo_pkg::record_t want;
      if (expected_records.size() == 0) begin
        failures++;
        if (failures <= SHOWN_MISMATCHES)
          $display("record with mask %h arrived with none expected", got.mask);
        return;
      end
      want = expected_records.pop_front();
      compare("present_mask", 64'(want.mask), 64'(got.mask));
      for (int i = 0; i < 6; i++)
        compare(value_names[i], 64'(want.vals[i]), 64'(got.vals[i]));
      compare("instrument_text", want.instrument, got.instrument);
      compare("instrument_length", 64'(want.instr_len), 64'(got.instr_len));
      compare("status", 64'(want.status), 64'(got.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tvo_cfg_if cfg_bus ();
  tvo_in_if in_bus ();
  tvo_out_if out_bus ();

  tag_value_order_message_parser dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  parser_scoreboard parser_model = new();
  bit idle_on;
  bit hold_request;
  int unsigned byte_count;
  int unsigned records_sent;
  int unsigned cycle_count;
  logic [7:0] message[$];

  string extreme_numbers[7] = '{"2147483647", "-2147483648", "2147483648", "-2147483649",
                                "99999999999", "+0", "-0"};
  string junk_numbers[7] = '{"x5", "+", "-", " ", "+-3", "7 8", "--1"};
  string field_keys[12] = '{"11", "1", "54", "38", "40", "44", "55",
                            "5", "111", "12", "", "0"};
  logic [7:0] phase_separators[PHASES] = '{8'h01, 8'h00, 8'hFF, tvo_pkg::CHAR_EQUALS,
                                           8'h00, tvo_pkg::SEP_RESET};
  string directed_messages[7] = '{
    "11=-2147483648|1=2147483647|55=ABCDEFGH|54= \t+1x|38=0|40=7=|44=-5|",
    "11=2147483648|55=ABCDEFGHI|1=abc",
    "55=ABCDEFGHI|11=+|38=",
    "9=1|=5|11=|1=2=3||54=\n-0|111=4",
    "11=1|11=99|1=-2147483649|44=  -17xyz",
    "|",
    "7"
  };

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog on the whole run.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Record receiver: checks each accepted item and stalls in random bursts.
  initial begin
    tvo_pkg::record_t got;
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got.vals[0] = out_bus.order_id;
        got.vals[1] = out_bus.client_id;
        got.vals[2] = out_bus.side_code;
        got.vals[3] = out_bus.order_quantity;
        got.vals[4] = out_bus.order_kind;
        got.vals[5] = out_bus.limit_price;
        got.instrument = out_bus.instrument_text;
        got.instr_len = out_bus.instrument_length;
        got.mask = out_bus.present_mask;
        got.status = out_bus.status;
        parser_model.check_record(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Appends one byte to the message being built.
  function void add_byte(logic [7:0] b);
    message.insert(message.size(), b);
  endfunction

  function void push_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // Numeric values: plain, random 32-bit, extremes, padded and signed, and malformed.
  function void push_number();
    case ($urandom_range(0, 7))
      0, 1: push_text($sformatf("%0d", $urandom_range(0, 99999)));
      2: push_text($sformatf("%0d", $signed($urandom())));
      3: push_text(extreme_numbers[$urandom_range(0, 6)]);
      4: begin
        repeat ($urandom_range(1, 3))
          add_byte(($urandom_range(0, 5) == 0) ? 8'(tvo_pkg::CHAR_SPACE) :
                   8'(tvo_pkg::CHAR_TAB + $urandom_range(0, 4)));
        push_text($sformatf("%s%0d", ($urandom_range(0, 1) ? "+" : "-"),
                            $urandom_range(0, 9999)));
      end
      5: push_text(junk_numbers[$urandom_range(0, 6)]);
      6: begin
        push_text($sformatf("%0d", $urandom_range(0, 999)));
        add_byte(8'($urandom_range(8'h21, 8'h7E)));
      end
      default: push_text($sformatf("-%0d", $urandom()));
    endcase
  endfunction

  // Instrument text, now and then longer than the record holds.
  function void push_instrument();
    int len;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(INSTR_BYTES + 1, 12) :
                                        $urandom_range(1, INSTR_BYTES);
    repeat (len)
      add_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(8'h30, 8'h39)) :
                                             8'($urandom_range(8'h41, 8'h5A)));
  endfunction

  function void push_value(string key);
    if (key == "55") push_instrument();
    else push_number();
  endfunction

  // One field, mostly well formed, sometimes with empty, extra or doubled pieces.
  function void push_field();
    int key_pick;
    string key;
    key_pick = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : $urandom_range(7, 11);
    key = field_keys[key_pick];
    push_text(key);
    case ($urandom_range(0, 11))
      0: if ($urandom_range(0, 1)) add_byte(tvo_pkg::CHAR_EQUALS);
      1: begin
        add_byte(tvo_pkg::CHAR_EQUALS);
        push_value(key);
        add_byte(tvo_pkg::CHAR_EQUALS);
      end
      2: begin
        add_byte(tvo_pkg::CHAR_EQUALS);
        push_value(key);
        add_byte(tvo_pkg::CHAR_EQUALS);
        push_value(key);
      end
      3: begin
        add_byte(tvo_pkg::CHAR_EQUALS);
        add_byte(tvo_pkg::CHAR_EQUALS);
        push_value(key);
      end
      default: begin
        add_byte(tvo_pkg::CHAR_EQUALS);
        push_value(key);
      end
    endcase
  endfunction

  // A message of a few fields, or now and then plain noise bytes.
  function void build_message();
    int fields;
    message.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    fields = $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) add_byte(parser_model.separator);
    for (int i = 0; i < fields; i++) begin
      if (i > 0) add_byte(parser_model.separator);
      push_field();
    end
    if ($urandom_range(0, 4) == 0 || message.size() == 0)
      add_byte(parser_model.separator);
  endfunction

  // Offers one input item and waits for it to be taken.
  task automatic send_byte(input logic [7:0] b, input bit last);
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.is_last <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    parser_model.note_byte(b, last);
    byte_count++;
    if (last) records_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_message();
    for (int i = 0; i < message.size(); i++) send_byte(message[i], i == message.size() - 1);
  endtask

  // Stops sending until every expected record is out and the pipeline is empty.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (parser_model.expected_records.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_separator(input logic [7:0] sep);
    cfg_bus.valid <= 1'b1;
    cfg_bus.field_separator <= sep;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    parser_model.separator = sep;
  endtask

  // Main sequence: reset, directed messages, then random phases per separator.
  initial begin
    int unsigned base;
    int unsigned target;
    rst_n <= 1'b0;
    idle_on = 1'b0;
    hold_request = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.data_byte <= 8'h00;
    in_bus.is_last <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.field_separator <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_messages[i]) begin
      idle_on = $urandom_range(0, 1);
      message.delete();
      push_text(directed_messages[i]);
      send_message();
    end

    base = byte_count;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_separator((p == 4) ? 8'($urandom_range(0, 255)) : phase_separators[p]);
      if (p == 2) begin
        // Receiver holds off while short messages keep coming, so the input backs up.
        idle_on = 1'b0;
        hold_request = 1'b1;
        repeat (12) begin
          message.delete();
          push_text($sformatf("11=%0d", $urandom_range(0, 999)));
          send_message();
        end
        drain();
      end
      target = base + (p + 1) * (ITEM_GOAL - base) / PHASES;
      while (byte_count < target || (p == PHASES - 1 && records_sent < MIN_RECORDS)) begin
        idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        build_message();
        send_message();
      end
    end
    drain();

    if (parser_model.failures == 0 && parser_model.expected_records.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/tvo_pkg.sv
rtl/tvo_if.sv
rtl/tvo_field.sv
rtl/tvo_record.sv
rtl/tag_value_order_message_parser.sv
test/tb_tag_value_order_message_parser.sv
